FILE: sv/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cds_pkg;

  // Default width of the year counter.
  localparam int YEAR_BITS_DEF = 16;
  // Width of the year field of a load beat.
  localparam int LOAD_BITS = 16;
  // Remainder of the year modulo 400 fits in 9 bits.
  localparam int MOD_W = 9;
  localparam int YEAR_CYCLE = 400;
  localparam int DEFAULT_YEAR = 2023;
  localparam int DEFAULT_MOD = DEFAULT_YEAR % YEAR_CYCLE;
  localparam int MONTHS = 12;

  // Year / 400 as (year >> 4) / 25; 5243 / 2^17 stands in for 1/25 and is exact
  // for every 12-bit dividend.
  localparam int RECIP_25 = 5243;
  localparam int RECIP_W = 13;
  localparam int RECIP_SHIFT = 17;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_REM,
    ST_LOAD_SET,
    ST_ADD,
    ST_SUB,
    ST_RESP
  } state_t;

  // Leap test on the year modulo 400 (4/100/400 rule).
  function automatic logic leap_of(input logic [MOD_W-1:0] r);
    logic century;
    century = (r == MOD_W'(100)) || (r == MOD_W'(200)) || (r == MOD_W'(300));
    return (r[1:0] == 2'b00) && !century;
  endfunction

  // Days in month m; 0 for a month code that names no month.
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: sv/calendar_date_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: the year modulo 400 is found first (quotient by shift and reciprocal, then remainder).
// Add: one calendar day per cycle through the step unit; subtract: one day back through it.
// The unused opcode leaves the date as it is. One command at a time; busy is high meanwhile
// and drops the cycle after the result; a new beat is taken only while busy is low.
// The result beat is shown for one cycle on done; the receiver cannot stall it.
// Synchronous reset sets the date to 1/1/2023 and returns the sequencer to idle.
module calendar_date_stepper #(
  parameter int YEAR_BITS = cds_pkg::YEAR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [5:0]  load_day,
  input  wire logic [3:0]  load_month,
  input  wire logic [15:0] load_year,
  input  wire logic [15:0] day_count,
  output logic             done,
  output logic [4:0]       day,
  output logic [3:0]       month,
  output logic [15:0]      year,
  output logic             leap_year,
  output logic             defaulted,
  output logic             range_hit
);
  import cds_pkg::*;

  localparam logic [32:0] YEAR_MAX = (33'd1 << YEAR_BITS) - 33'd1;

  state_t state;
  state_t state_next;

  // Current date and the year modulo 400 kept alongside for the leap test.
  logic [4:0]           cur_day;
  logic [3:0]           cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic [MOD_W-1:0]     cur_mod;

  // Captured command beat.
  logic [5:0]           ld_day;
  logic [3:0]           ld_month;
  logic [LOAD_BITS-1:0] ld_year;
  logic [15:0]          cnt;
  logic                 dflt;
  logic                 hit;

  logic accept;
  logic mod_start;
  logic mod_busy;
  logic [MOD_W-1:0] mod_rem;

  logic                 step_back;
  logic [4:0]           st_day;
  logic [3:0]           st_month;
  logic [YEAR_BITS-1:0] st_year;
  logic [MOD_W-1:0]     st_mod;
  logic                 st_limit;

  logic        load_ok;
  logic [32:0] ld_year_wide;
  logic [32:0] cur_year_wide;

  assign accept = start && !busy;

  // Remainder of the load year modulo 400, needed for the February check.
  cds_mod400 u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (load_year),
    .rem   (mod_rem),
    .busy  (mod_busy)
  );

  // One-day step unit, shared by add (forward) and subtract (back).
  cds_step #(
    .YEAR_BITS (YEAR_BITS)
  ) u_step (
    .back      (step_back),
    .day_in    (cur_day),
    .month_in  (cur_month),
    .year_in   (cur_year),
    .ymod_in   (cur_mod),
    .day_out   (st_day),
    .month_out (st_month),
    .year_out  (st_year),
    .ymod_out  (st_mod),
    .limit     (st_limit)
  );

  // Validate the captured load against month range, year range and month length.
  assign ld_year_wide = 33'(ld_year);
  assign load_ok = (ld_month >= 4'd1) && (ld_month <= 4'(MONTHS)) &&
                   (ld_year != '0) && (ld_year_wide <= YEAR_MAX) &&
                   (ld_day != '0) &&
                   (ld_day <= 6'(days_in(ld_month, leap_of(mod_rem))));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_LOAD: state_next = ST_LOAD_REM;
            OP_ADD:  state_next = ST_ADD;
            OP_SUB:  state_next = ST_SUB;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_LOAD_REM: begin
        if (!mod_busy) begin
          state_next = ST_LOAD_SET;
        end
      end
      ST_LOAD_SET: state_next = ST_RESP;
      ST_ADD: begin
        // Finish on an empty count, the last day, or the top of the year range.
        if ((cnt <= 16'd1) || st_limit) begin
          state_next = ST_RESP;
        end
      end
      ST_SUB:  state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy      = (state != ST_IDLE);
    done      = (state == ST_RESP);
    mod_start = (state == ST_IDLE) && start && (opcode_t'(opcode) == OP_LOAD);
    step_back = (state == ST_SUB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_day   <= 5'd1;
      cur_month <= 4'd1;
      cur_year  <= YEAR_BITS'(DEFAULT_YEAR);
      cur_mod   <= MOD_W'(DEFAULT_MOD);
      dflt      <= 1'b0;
      hit       <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        ld_day   <= load_day;
        ld_month <= load_month;
        ld_year  <= load_year;
        cnt      <= day_count;
        dflt     <= 1'b0;
        hit      <= 1'b0;
      end
      case (state)
        ST_LOAD_SET: begin
          if (load_ok) begin
            cur_day   <= ld_day[4:0];
            cur_month <= ld_month;
            cur_year  <= ld_year_wide[YEAR_BITS-1:0];
            cur_mod   <= mod_rem;
          end else begin
            // Fall back to the default date.
            cur_day   <= 5'd1;
            cur_month <= 4'd1;
            cur_year  <= YEAR_BITS'(DEFAULT_YEAR);
            cur_mod   <= MOD_W'(DEFAULT_MOD);
            dflt      <= 1'b1;
          end
        end
        ST_ADD: begin
          if (cnt != '0) begin
            if (st_limit) begin
              // Hold the date at the top and drop the remaining days.
              hit <= 1'b1;
            end else begin
              cur_day   <= st_day;
              cur_month <= st_month;
              cur_year  <= st_year;
              cur_mod   <= st_mod;
              cnt       <= cnt - 16'd1;
            end
          end
        end
        ST_SUB: begin
          if (st_limit) begin
            hit <= 1'b1;
          end else begin
            cur_day   <= st_day;
            cur_month <= st_month;
            cur_year  <= st_year;
            cur_mod   <= st_mod;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result beat comes straight from the date registers and the flags.
  assign cur_year_wide = 33'(cur_year);
  assign day       = cur_day;
  assign month     = cur_month;
  assign year      = cur_year_wide[15:0];
  assign leap_year = leap_of(cur_mod);
  assign defaulted = dflt;
  assign range_hit = hit;

endmodule
`default_nettype wire

FILE: sv/cds_mod400.sv
`timescale 1ns / 1ps
`default_nettype none
module cds_mod400 (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [cds_pkg::LOAD_BITS-1:0] value,
  output logic      [cds_pkg::MOD_W-1:0]     rem,
  output logic                               busy
);
  import cds_pkg::*;

  localparam int STEPS = 2;
  localparam int CNT_W = 2;
  localparam int X_W   = LOAD_BITS - 4;
  localparam int P_W   = X_W + RECIP_W;
  localparam int Q_W   = P_W - RECIP_SHIFT;

  logic [LOAD_BITS-1:0] val;
  logic [Q_W-1:0]       quot;
  logic [CNT_W-1:0]     cnt;
  logic [P_W-1:0]       prod;
  logic [LOAD_BITS-1:0] diff;

  // Quotient by 400: shift out the factor 16, then multiply by the reciprocal of 25.
  assign prod = P_W'(val[LOAD_BITS-1:4]) * P_W'(RECIP_25);
  // Remainder from the registered quotient; below 400 once that quotient is the one of val.
  assign diff = val - LOAD_BITS'(quot) * LOAD_BITS'(YEAR_CYCLE);

  // The quotient is registered first, then the remainder from it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(STEPS);
      val <= value;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNT_W'(1);
      quot <= prod[P_W-1:RECIP_SHIFT];
      rem  <= diff[MOD_W-1:0];
    end
  end

  assign busy = (cnt != '0);

endmodule
`default_nettype wire

FILE: sv/cds_step.sv
`timescale 1ns / 1ps
`default_nettype none
module cds_step #(
  parameter int YEAR_BITS = cds_pkg::YEAR_BITS_DEF
) (
  input  wire logic                       back,
  input  wire logic [4:0]                 day_in,
  input  wire logic [3:0]                 month_in,
  input  wire logic [YEAR_BITS-1:0]       year_in,
  input  wire logic [cds_pkg::MOD_W-1:0]  ymod_in,
  output logic      [4:0]                 day_out,
  output logic      [3:0]                 month_out,
  output logic      [YEAR_BITS-1:0]       year_out,
  output logic      [cds_pkg::MOD_W-1:0]  ymod_out,
  output logic                            limit
);
  import cds_pkg::*;

  logic       leap;
  logic [4:0] dim;
  logic [4:0] dim_prev;

  assign leap     = leap_of(ymod_in);
  assign dim      = days_in(month_in, leap);
  assign dim_prev = days_in(month_in - 4'd1, leap);

  always_comb begin
    day_out   = day_in;
    month_out = month_in;
    year_out  = year_in;
    ymod_out  = ymod_in;
    limit     = 1'b0;
    if (!back) begin
      if (day_in >= dim) begin
        if (month_in >= 4'(MONTHS)) begin
          if (&year_in) begin
            limit = 1'b1;
          end else begin
            year_out  = year_in + YEAR_BITS'(1);
            month_out = 4'd1;
            day_out   = 5'd1;
            ymod_out  = (ymod_in == MOD_W'(YEAR_CYCLE - 1)) ? '0 : ymod_in + MOD_W'(1);
          end
        end else begin
          month_out = month_in + 4'd1;
          day_out   = 5'd1;
        end
      end else begin
        day_out = day_in + 5'd1;
      end
    end else begin
      if (day_in <= 5'd1) begin
        if (month_in <= 4'd1) begin
          if (year_in <= YEAR_BITS'(1)) begin
            limit = 1'b1;
          end else begin
            year_out  = year_in - YEAR_BITS'(1);
            month_out = 4'(MONTHS);
            day_out   = 5'd31;
            ymod_out  = (ymod_in == '0) ? MOD_W'(YEAR_CYCLE - 1) : ymod_in - MOD_W'(1);
          end
        end else begin
          // Last day of the previous month of the same year (February when stepping back from March).
          month_out = month_in - 4'd1;
          day_out   = dim_prev;
        end
      end else begin
        day_out = day_in - 5'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/calendar_date_stepper_tb.sv
`timescale 1ns / 1ps
module calendar_date_stepper_tb;
  import cds_pkg::*;

  // Top of the year range for the default YEAR_BITS.
  localparam int unsigned YR_MAX = (1 << YEAR_BITS_DEF) - 1;

  // One command beat as it is queued for the driver.
  typedef struct {
    opcode_t     op;
    logic [5:0]  ld;
    logic [3:0]  lm;
    logic [15:0] ly;
    logic [15:0] cnt;
    int unsigned idle;   // chance in a hundred that the driver skips a cycle
    bit          drain;  // hold this beat back until every result is in
  } cmd_t;

  // One result beat.
  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        leap;
    logic        dflt;
    logic        hit;
  } date_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = '0;
  logic [5:0]  load_day = '0;
  logic [3:0]  load_month = '0;
  logic [15:0] load_year = '0;
  logic [15:0] day_count = '0;
  logic        busy;
  logic        done;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [15:0] year;
  logic        leap_year;
  logic        defaulted;
  logic        range_hit;

  calendar_date_stepper u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .load_day   (load_day),
    .load_month (load_month),
    .load_year  (load_year),
    .day_count  (day_count),
    .done       (done),
    .day        (day),
    .month      (month),
    .year       (year),
    .leap_year  (leap_year),
    .defaulted  (defaulted),
    .range_hit  (range_hit)
  );

  // 4 ns period: 2 ns high, 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cmd_t       cmd_q[$];
  date_beat_t date_q[$];

  // Calendar state the predictor keeps; starts at the reset date 1/1/2023.
  logic [4:0]  cal_day = 5'd1;
  logic [3:0]  cal_month = 4'd1;
  logic [15:0] cal_year = 16'(DEFAULT_YEAR);

  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned errors = 0;
  int unsigned n_load = 0, n_dflt = 0, n_add = 0, n_sub = 0, n_hit = 0;
  longint unsigned cyc = 0;
  longint unsigned cycle_limit = 64'd1 << 40;
  longint unsigned budget = 0;
  int unsigned idle_now = 26;
  bit          drain_next = 1'b0;

  // ---------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------

  function automatic bit leap_yr(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_yr(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Advance one day; refuse (and hold the date) past 31/12 of the top year.
  function automatic bit step_fwd();
    if (cal_day >= month_len(cal_month, cal_year)) begin
      if (cal_month >= 12) begin
        if (cal_year >= YR_MAX) return 1'b0;
        cal_year++;
        cal_month = 4'd1;
      end else begin
        cal_month++;
      end
      cal_day = 5'd1;
    end else begin
      cal_day++;
    end
    return 1'b1;
  endfunction

  // Go back one day; refuse (and hold the date) at 1/1/1.
  function automatic bit step_back();
    if (cal_day <= 1) begin
      if (cal_month <= 1) begin
        if (cal_year <= 1) return 1'b0;
        cal_year--;
        cal_month = 4'd12;
      end else begin
        cal_month--;
      end
      cal_day = 5'(month_len(cal_month, cal_year));
    end else begin
      cal_day--;
    end
    return 1'b1;
  endfunction

  // Apply one accepted command to the calendar and return the date beat it yields.
  function automatic date_beat_t apply_cmd(input cmd_t c);
    date_beat_t r;
    bit ok;
    r.dflt = 1'b0;
    r.hit = 1'b0;
    case (c.op)
      OP_LOAD: begin
        n_load++;
        ok = (c.lm >= 1) && (c.lm <= 12) && (c.ly >= 1) && (c.ly <= YR_MAX);
        if (ok) ok = (c.ld >= 1) && (c.ld <= month_len(c.lm, c.ly));
        if (ok) begin
          cal_day = c.ld[4:0];
          cal_month = c.lm;
          cal_year = c.ly;
        end else begin
          // Nonexistent date: fall back to 1/1/2023.
          cal_day = 5'd1;
          cal_month = 4'd1;
          cal_year = 16'(DEFAULT_YEAR);
          r.dflt = 1'b1;
          n_dflt++;
        end
      end
      OP_ADD: begin
        n_add++;
        for (int unsigned k = 0; k < c.cnt; k++) begin
          if (!step_fwd()) begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      OP_SUB: begin
        n_sub++;
        if (!step_back()) r.hit = 1'b1;
      end
      default: ;  // unused opcode: date unchanged, both flags low
    endcase
    if (r.hit) n_hit++;
    r.day = cal_day;
    r.month = cal_month;
    r.year = cal_year;
    r.leap = leap_yr(cal_year);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic cmd_t mk(input opcode_t op, input int unsigned ld, input int unsigned lm,
                              input int unsigned ly, input int unsigned cnt);
    cmd_t c;
    c.op = op;
    c.ld = 6'(ld);
    c.lm = 4'(lm);
    c.ly = 16'(ly);
    c.cnt = 16'(cnt);
    c.idle = 0;
    c.drain = 1'b0;
    return c;
  endfunction

  // Queue a beat, stamp the current idle rate, and add its worst case to the budget.
  task automatic push(input cmd_t c);
    c.idle = idle_now;
    c.drain = drain_next;
    drain_next = 1'b0;
    cmd_q.push_back(c);
    budget += (c.op == OP_ADD ? c.cnt : 0) + 40;
  endtask

  // A load of a date that exists, biased to month ends, centuries and range edges.
  function automatic cmd_t valid_load();
    int unsigned m, y, len, d;
    m = $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(1, 3);
      1:       y = $urandom_range(65530, 65535);
      2:       y = $urandom_range(1, 655) * 100;
      3:       y = $urandom_range(1, 65535);
      default: y = $urandom_range(1896, 2104);
    endcase
    len = month_len(m, y);
    d = $urandom_range(0, 1) ? $urandom_range(len - 1, len) : $urandom_range(1, len);
    return mk(OP_LOAD, d, m, y, $urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present queued beats on start, hold each until accepted
  // ---------------------------------------------------------------------

  cmd_t        cur_cmd;
  int unsigned owed;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // Beat accepted at this edge: predict its result now.
        date_q.push_back(apply_cmd(cur_cmd));
        n_accepted++;
      end
      if (start && busy) begin
        // Hold the beat until the block takes it.
      end else begin
        // Results still owed, counting the one on the ports this cycle as arrived.
        owed = n_accepted - n_results - (done ? 1 : 0);
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= cmd_q[0].idle &&
            !(cmd_q[0].drain && owed != 0)) begin
          cur_cmd = cmd_q.pop_front();
          opcode <= cur_cmd.op;
          load_day <= cur_cmd.ld;
          load_month <= cur_cmd.lm;
          load_year <= cur_cmd.ly;
          day_count <= cur_cmd.cnt;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: take each done beat and compare with the oldest prediction
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  date_beat_t want_date;

  always @(posedge clk) begin
    if (!rst && done) begin
      n_results <= n_results + 1;
      if (date_q.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual %0d/%0d/%0d",
                 $time, day, month, year);
        errors++;
      end else begin
        want_date = date_q.pop_front();
        check_field("day", want_date.day, day);
        check_field("month", want_date.month, month);
        check_field("year", want_date.year, year);
        check_field("leap_year", want_date.leap, leap_year);
        check_field("defaulted", want_date.dflt, defaulted);
        check_field("range_hit", want_date.hit, range_hit);
      end
    end
  end

  // Watchdog: stop a run that hangs.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > cycle_limit) begin
      $display("%0t: timeout after %0d cycles", $time, cyc);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: fill the command queue, release reset, wait for the drain
  // ---------------------------------------------------------------------

  int unsigned r;

  initial begin
    // Directed: range edges, leap rules, every invalid-load cause, every opcode.
    push(mk(OP_NOP, 0, 0, 0, 0));              // reset date comes back unchanged
    push(mk(OP_LOAD, 31, 12, 65535, 0));       // last day of the range
    push(mk(OP_ADD, 0, 0, 0, 1));              // step past the top: hold
    push(mk(OP_SUB, 0, 0, 0, 0));
    push(mk(OP_ADD, 63, 15, 65535, 5));        // reach the top, drop the rest
    push(mk(OP_LOAD, 1, 1, 1, 0));             // first day of the range
    push(mk(OP_SUB, 0, 0, 0, 0));              // step below the bottom: hold
    push(mk(OP_ADD, 0, 0, 0, 0));              // zero count does nothing
    push(mk(OP_LOAD, 29, 2, 2024, 0));         // leap day, divisible by 4
    push(mk(OP_LOAD, 29, 2, 2023, 0));         // no leap day in a common year
    push(mk(OP_LOAD, 29, 2, 1900, 0));         // century is not leap
    push(mk(OP_LOAD, 29, 2, 2000, 0));         // 400-year century is leap
    push(mk(OP_LOAD, 1, 0, 2020, 0));          // month zero
    push(mk(OP_LOAD, 1, 13, 2020, 0));         // month past December
    push(mk(OP_LOAD, 63, 15, 0, 65535));       // everything out of range
    push(mk(OP_LOAD, 5, 6, 0, 0));             // year zero
    push(mk(OP_LOAD, 0, 6, 2020, 0));          // day zero
    push(mk(OP_LOAD, 31, 4, 2020, 0));         // day past a 30-day month
    push(mk(OP_LOAD, 1, 3, 2000, 0));
    push(mk(OP_SUB, 0, 0, 0, 0));              // back into 29 February
    push(mk(OP_LOAD, 1, 3, 1900, 0));
    push(mk(OP_SUB, 0, 0, 0, 0));              // back into 28 February
    push(mk(OP_LOAD, 31, 12, 2023, 0));
    push(mk(OP_ADD, 0, 0, 0, 1));              // year rollover
    push(mk(OP_LOAD, 1, 1, 65535, 0));
    push(mk(OP_ADD, 0, 0, 0, 400));            // runs into the top mid-count
    push(mk(OP_LOAD, 1, 1, 1, 0));
    push(mk(OP_ADD, 0, 0, 0, 65535));          // largest count

    // Random: mostly valid loads followed by steps, some noise loads.
    for (int i = 0; i < 420; i++) begin
      // Switch idle rate at phase boundaries; drain the pipe before each switch.
      if (i == 140) begin
        idle_now = 74;
        drain_next = 1'b1;
      end
      if (i == 280) begin
        idle_now = 0;
        drain_next = 1'b1;
      end
      if (i % 100 == 50) begin
        // Full-width count, every bit free.
        push(mk(OP_ADD, $urandom, $urandom, $urandom, $urandom));
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 22) begin
        push(valid_load());
      end else if (r < 30) begin
        push(mk(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 15), $urandom, $urandom));
      end else if (r < 62) begin
        push(mk(OP_ADD, $urandom, $urandom, $urandom, $urandom_range(0, 40)));
      end else if (r < 66) begin
        push(mk(OP_ADD, $urandom, $urandom, $urandom, $urandom_range(41, 1500)));
      end else if (r < 92) begin
        push(mk(OP_SUB, $urandom, $urandom, $urandom, $urandom));
      end else if (r < 96) begin
        push(mk(OP_NOP, $urandom, $urandom, $urandom, $urandom));
      end else if (r < 98) begin
        // Probe the top of the range from late December.
        push(mk(OP_LOAD, $urandom_range(20, 31), 12, 65535 - $urandom_range(0, 1), $urandom));
        push(mk(OP_ADD, $urandom, $urandom, $urandom, $urandom_range(1, 45)));
      end else begin
        // Probe the bottom of the range from early January of year 1.
        push(mk(OP_LOAD, $urandom_range(1, 3), 1, 1, $urandom));
        repeat ($urandom_range(1, 4)) push(mk(OP_SUB, $urandom, $urandom, $urandom, $urandom));
      end
    end

    // Several times the slowest plausible run, plus a clearing margin.
    cycle_limit = 4 * budget + 2000;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to go out and every result to come back.
    do @(posedge clk);
    while (cmd_q.size() != 0 || start || n_accepted != n_results);
    repeat (40) @(posedge clk);

    if (date_q.size() != 0) begin
      $display("%0t: %0d results never arrived: expected 0 pending, actual %0d",
               $time, date_q.size(), date_q.size());
      errors += date_q.size();
    end

    $display("Ran %0d commands: %0d loads (%0d fell back to default), %0d adds, %0d subtracts",
             n_accepted, n_load, n_dflt, n_add, n_sub);
    $display("Year-range stops hit %0d times; %0d mismatches", n_hit, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cds_pkg.sv
sv/cds_mod400.sv
sv/cds_step.sv
sv/calendar_date_stepper.sv
tb/sv/calendar_date_stepper_tb.sv
